>>> rtl/key_autorepeat_detector_assert.svh
// assertion macros for the key autorepeat detector checker
`ifndef KEY_AUTOREPEAT_DETECTOR_ASSERT_SVH
`define KEY_AUTOREPEAT_DETECTOR_ASSERT_SVH

// checked on every clock edge once reset is released
`define KAD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define KAD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/kad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kad_pkg;

    localparam int KEY_COUNT = 11;
    localparam int G1_W      = 18;
    localparam int G2_W      = 14;
    localparam int MS_W      = 32;
    localparam int DELAY_W   = 16;
    localparam int CFG_IDX_W = 8;

    typedef logic [3:0]         key_idx_t;
    typedef logic [G1_W-1:0]    g1_t;
    typedef logic [G2_W-1:0]    g2_t;
    typedef logic [MS_W-1:0]    ms_t;
    typedef logic [DELAY_W-1:0] delay_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes on the config channel
    localparam cfg_idx_t CFG_FIRST_DELAY  = 8'd0;
    localparam cfg_idx_t CFG_REPEAT_DELAY = 8'd1;

    localparam delay_t FIRST_DELAY_RST  = 16'd500;
    localparam delay_t REPEAT_DELAY_RST = 16'd175;

    // key table in priority order: entry i is key index i+1
    localparam logic [KEY_COUNT-1:0] KEY_IN_GROUP2 = 11'b000_0000_0011;

    localparam logic [G1_W-1:0] KEY_MASK [KEY_COUNT] = '{
        18'h02002,
        18'h02000,
        18'h00400,
        18'h20000,
        18'h08000,
        18'h00800,
        18'h01000,
        18'h00008,
        18'h00002,
        18'h10000,
        18'h00080
    };

    typedef struct packed {
        key_idx_t               pressed;
        key_idx_t               clicked;
        logic [KEY_COUNT-1:0]   down;
    } kad_match_t;

endpackage

`default_nettype wire

>>> rtl/kad_match.sv
`timescale 1ns / 1ps
`default_nettype none

module kad_match
    import kad_pkg::*;
(
    input  wire g1_t        group1,
    input  wire g2_t        group2,
    input  wire g1_t        prev_group1,
    input  wire g2_t        prev_group2,
    output kad_match_t      result
);

    logic [KEY_COUNT-1:0] now_down;
    logic [KEY_COUNT-1:0] was_down;

    // per-key pressed state, now and on the last scan
    always_comb
    begin
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (KEY_IN_GROUP2[i])
            begin
                now_down[i] = ({{(G1_W-G2_W){1'b0}}, group2} & KEY_MASK[i]) == '0;
                was_down[i] = ({{(G1_W-G2_W){1'b0}}, prev_group2} & KEY_MASK[i]) == '0;
            end
            else
            begin
                now_down[i] = (group1 & KEY_MASK[i]) == '0;
                was_down[i] = (prev_group1 & KEY_MASK[i]) == '0;
            end
        end
    end

    // first hit in table order wins, so walk from the back
    always_comb
    begin
        result.pressed = '0;
        result.clicked = '0;
        result.down    = now_down;
        for (int i = KEY_COUNT - 1; i >= 0; i--)
        begin
            if (now_down[i])
            begin
                result.pressed = key_idx_t'(i + 1);
            end
            if (now_down[i] && !was_down[i])
            begin
                result.clicked = key_idx_t'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/key_autorepeat_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    tuser: func; tdata: group1_keys, group2_keys, now_ms
// m_        out  m_tvalid / m_tready    tuser: is_repeat; tdata: auto_key, pressed_key
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data (first_delay_ms, repeat_delay_ms)
//
// one scan per cycle while the result register can take it: a transfer lands in the
// input register, then the key match and the hold-time compare run and load the
// result register once it is free, which raises m_tvalid
// stalls on m_ stop the input register only when the result register is full
// and not being taken; s_tready never waits on an idle state
// rst_n clears the key history, the hold state and loads the default delays

module key_autorepeat_detector
    import kad_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,    // [17:0] group1_keys, [31:18] group2_keys, [63:32] now_ms
    input  wire         s_tuser,    // [0] func: 0 scan, 1 forget held key

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // [3:0] auto_key, [7:4] pressed_key
    output logic        m_tuser,    // [0] is_repeat

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    // config registers
    delay_t   first_delay_reg;
    delay_t   repeat_delay_reg;

    // input register
    logic     in_valid_reg;
    logic     func_reg;
    g1_t      g1_reg;
    g2_t      g2_reg;
    ms_t      now_reg;

    // detector state
    g1_t      prev_g1_reg,    prev_g1_next;
    g2_t      prev_g2_reg,    prev_g2_next;
    key_idx_t held_key_reg,   held_key_next;
    ms_t      hold_start_reg, hold_start_next;
    logic     repeating_reg,  repeating_next;

    // result register
    logic     out_valid_reg,  out_valid_next;
    key_idx_t auto_key_reg,   auto_key_next;
    key_idx_t pressed_reg,    pressed_next;
    logic     is_repeat_reg,  is_repeat_next;

    kad_match_t match;
    logic       out_free;
    logic       advance;
    logic       held_down;
    ms_t        elapsed;
    delay_t     limit;

    assign cfg_ready = 1'b1;

    // result slot frees up when empty or drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pressed_reg, auto_key_reg};
    assign m_tuser  = is_repeat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg  <= FIRST_DELAY_RST;
            repeat_delay_reg <= REPEAT_DELAY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIRST_DELAY:  first_delay_reg  <= cfg_data;
                CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                default:          ;  // unknown index, dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser;
            g1_reg   <= s_tdata[17:0];
            g2_reg   <= s_tdata[31:18];
            now_reg  <= s_tdata[63:32];
        end
    end

    kad_match u_match (
        .group1      (g1_reg),
        .group2      (g2_reg),
        .prev_group1 (prev_g1_reg),
        .prev_group2 (prev_g2_reg),
        .result      (match)
    );

    // held key still down in this scan
    always_comb
    begin
        held_down = 1'b0;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (held_key_reg == key_idx_t'(i + 1) && match.down[i])
            begin
                held_down = 1'b1;
            end
        end
    end

    // wrapping tick difference against the active delay
    assign limit   = repeating_reg ? repeat_delay_reg : first_delay_reg;
    assign elapsed = now_reg - hold_start_reg;

    always_comb
    begin
        prev_g1_next    = prev_g1_reg;
        prev_g2_next    = prev_g2_reg;
        held_key_next   = held_key_reg;
        hold_start_next = hold_start_reg;
        repeating_next  = repeating_reg;
        auto_key_next   = '0;
        pressed_next    = '0;
        is_repeat_next  = 1'b0;

        if (func_reg)
        begin
            // forget request: drop the hold, keep history and hold time
            held_key_next  = '0;
            repeating_next = 1'b0;
        end
        else
        begin
            pressed_next = match.pressed;
            prev_g1_next = g1_reg;
            prev_g2_next = g2_reg;
            if (match.clicked != '0)
            begin
                // fresh click restarts the hold timer
                held_key_next   = match.clicked;
                repeating_next  = 1'b0;
                hold_start_next = now_reg;
                auto_key_next   = match.clicked;
            end
            else if (held_down)
            begin
                if (elapsed > {{(MS_W-DELAY_W){1'b0}}, limit})
                begin
                    repeating_next  = 1'b1;
                    hold_start_next = now_reg;
                    auto_key_next   = held_key_reg;
                    is_repeat_next  = 1'b1;
                end
            end
            else
            begin
                // held key released, or nothing held
                held_key_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_g1_reg    <= '0;
            prev_g2_reg    <= '0;
            held_key_reg   <= '0;
            hold_start_reg <= '0;
            repeating_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prev_g1_reg    <= prev_g1_next;
            prev_g2_reg    <= prev_g2_next;
            held_key_reg   <= held_key_next;
            hold_start_reg <= hold_start_next;
            repeating_reg  <= repeating_next;
        end
    end

    // result register
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            auto_key_reg  <= auto_key_next;
            pressed_reg   <= pressed_next;
            is_repeat_reg <= is_repeat_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/kad_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "key_autorepeat_detector_assert.svh"

module kad_checker
(
    input wire       clk,
    input wire       rst_n,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tuser
);

    // a stalled result holds
    `KAD_ASSERT(a_out_hold,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result changed while stalled")

    // both key indexes stay inside the table
    `KAD_ASSERT(a_idx_range,
        m_tvalid |-> m_tdata[3:0] <= 4'd11 && m_tdata[7:4] <= 4'd11,
        "key index beyond table")

    // a repeat always names a key
    `KAD_ASSERT(a_repeat_key, m_tvalid && m_tuser |-> m_tdata[3:0] != 4'd0, "repeat without key")

    // a clicked or repeated key is down, so the first pressed key is at or ahead of it
    `KAD_ASSERT(a_auto_pressed,
        m_tvalid && m_tdata[3:0] != 4'd0 |-> m_tdata[7:4] != 4'd0 && m_tdata[7:4] <= m_tdata[3:0],
        "reported key not pressed")

    // an edge seen in reset leaves the result register empty
    `KAD_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind key_autorepeat_detector kad_checker u_kad_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import kad_pkg::*;

    // scan kinds carried in s_tuser
    localparam logic FUNC_SCAN   = 1'b0;
    localparam logic FUNC_FORGET = 1'b1;

    // register indexes past the end of the list, writes there are dropped
    localparam cfg_idx_t CFG_SPARE_IDX = 8'd2;
    localparam cfg_idx_t CFG_TOP_IDX   = 8'hFF;

    localparam int MAX_REPORTS = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 185;

    typedef struct packed {
        logic func;
        g1_t  g1;
        g2_t  g2;
        ms_t  now;
    } scan_t;

    typedef struct packed {
        key_idx_t auto_key;
        logic     is_repeat;
        key_idx_t pressed;
    } key_event_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = '0;
    delay_t      cfg_data  = '0;

    key_autorepeat_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // scans waiting for the driver, key events waiting for the monitor
    scan_t      pending_scans[$];
    key_event_t key_events_due[$];

    // shadow of the detector: key history, hold state and delays
    g1_t      last_g1        = '0;
    g2_t      last_g2        = '0;
    key_idx_t held_idx       = '0;
    ms_t      hold_mark      = '0;
    logic     in_repeat      = 1'b0;
    delay_t   first_delay_q  = FIRST_DELAY_RST;
    delay_t   repeat_delay_q = REPEAT_DELAY_RST;

    int    fail_count  = 0;
    int    cycle_count = 0;
    int    src_gap     = 0;
    int    snk_gap     = 0;
    int    stim_count  = 0;
    bit    quiet_tail  = 1'b0;
    ms_t   ms_clock    = '0;
    g1_t   used_g1     = '0;
    g2_t   used_g2     = '0;
    scan_t next_scan;

    // a key counts as down when every bit of its mask reads low
    function automatic logic key_is_down(input int i, input g1_t g1, input g2_t g2);
        if (KEY_IN_GROUP2[i])
            return (g2 & KEY_MASK[i][G2_W-1:0]) == '0;
        else
            return (g1 & KEY_MASK[i]) == '0;
    endfunction

    // work out the event for one accepted scan and advance the shadow state
    task automatic predict_key_event(input scan_t it);
        key_event_t ev;
        key_idx_t   clicked;
        ms_t        elapsed;
        delay_t     lim;
        logic       now_down;
        logic       was_down;
        ev = '0;
        clicked = '0;
        if (it.func == FUNC_FORGET)
        begin
            // drop the hold but keep key history and hold time
            held_idx = '0;
            in_repeat = 1'b0;
        end
        else
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                now_down = key_is_down(i, it.g1, it.g2);
                was_down = key_is_down(i, last_g1, last_g2);
                if (ev.pressed == '0 && now_down)
                    ev.pressed = key_idx_t'(i + 1);
                if (clicked == '0 && now_down && !was_down)
                    clicked = key_idx_t'(i + 1);
            end
            if (clicked != '0)
            begin
                // fresh click reported at once and restarts the hold timer
                held_idx = clicked;
                in_repeat = 1'b0;
                hold_mark = it.now;
                ev.auto_key = clicked;
            end
            else if (held_idx != '0 && key_is_down(int'(held_idx) - 1, it.g1, it.g2))
            begin
                // wrapping difference, must be strictly past the delay
                elapsed = it.now - hold_mark;
                lim = in_repeat ? repeat_delay_q : first_delay_q;
                if (elapsed > ms_t'(lim))
                begin
                    in_repeat = 1'b1;
                    hold_mark = it.now;
                    ev.auto_key = held_idx;
                    ev.is_repeat = 1'b1;
                end
            end
            else
            begin
                held_idx = '0;
            end
            last_g1 = it.g1;
            last_g2 = it.g2;
        end
        key_events_due.push_back(ev);
    endtask

    // driver: feeds queued scans, idles in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_key_event(scan_t'({s_tuser, s_tdata[17:0], s_tdata[31:18],
                                           s_tdata[63:32]}));
            // bus may change once the held scan has gone or none is held
            if (!s_tvalid || s_tready)
            begin
                if (src_gap != 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (!quiet_tail && pending_scans.size() != 0
                         && $urandom_range(0, 11) == 0)
                begin
                    // start an idle gap, this one included; src_gap holds the rest
                    src_gap <= $urandom_range(0, 16);
                    s_tvalid <= 1'b0;
                end
                else if (pending_scans.size() != 0)
                begin
                    next_scan = pending_scans.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_scan.func;
                    s_tdata <= {next_scan.now, next_scan.g2, next_scan.g1};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks every result transfer against the oldest expected event
    always @(posedge clk or negedge rst_n)
    begin
        key_event_t want;
        key_event_t got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.auto_key = m_tdata[3:0];
                got.pressed = m_tdata[7:4];
                got.is_repeat = m_tuser;
                if (key_events_due.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected result: auto_key %0d is_repeat %0d pressed %0d",
                                 got.auto_key, got.is_repeat, got.pressed);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = key_events_due.pop_front();
                    if (want != got)
                    begin
                        if (fail_count < MAX_REPORTS)
                        begin
                            $write("mismatch at %0t: auto_key %0d/%0d is_repeat %0d/%0d",
                                   $realtime, want.auto_key, got.auto_key,
                                   want.is_repeat, got.is_repeat);
                            $display(" pressed %0d/%0d (expected/actual)",
                                     want.pressed, got.pressed);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // receiver stalls in random bursts
            if (snk_gap != 0)
            begin
                snk_gap <= snk_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 11) == 0)
            begin
                snk_gap <= $urandom_range(0, 16);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** key_autorepeat_detector: FAILED **");
            $finish;
        end
    end

    task automatic push_scan(input g1_t g1, input g2_t g2, input ms_t now);
        scan_t it;
        it.func = FUNC_SCAN;
        it.g1 = g1;
        it.g2 = g2;
        it.now = now;
        pending_scans.push_back(it);
        stim_count++;
    endtask

    // forget request with random payload bits
    task automatic push_forget();
        scan_t it;
        it.func = FUNC_FORGET;
        it.g1 = g1_t'($urandom);
        it.g2 = g2_t'($urandom);
        it.now = $urandom;
        pending_scans.push_back(it);
        stim_count++;
    endtask

    // no key down, random noise on bits that no key uses
    task automatic idle_words(output g1_t g1, output g2_t g2);
        g1 = used_g1 | (g1_t'($urandom) & ~used_g1);
        g2 = used_g2 | (g2_t'($urandom) & ~used_g2);
    endtask

    task automatic press_key(input int k, inout g1_t g1, inout g2_t g2);
        if (k >= 1 && k <= KEY_COUNT)
        begin
            if (KEY_IN_GROUP2[k-1])
                g2 = g2 & ~KEY_MASK[k-1][G2_W-1:0];
            else
                g1 = g1 & ~KEY_MASK[k-1];
        end
    endtask

    // time step around the current delays so both sides of each compare get hit
    function automatic ms_t hold_gap();
        int unsigned lim;
        lim = $urandom_range(0, 1) ? 32'(first_delay_q) : 32'(repeat_delay_q);
        case ($urandom_range(0, 4))
            0: return lim;
            1: return lim + 1;
            2: return (lim == 0) ? 0 : lim - 1;
            3: return $urandom_range(0, lim);
            default: return $urandom_range(0, 2 * lim + 2);
        endcase
    endfunction

    // release, click key k, hold it through several scans
    task automatic hold_run(input int k);
        g1_t g1;
        g2_t g2;
        int  n;
        idle_words(g1, g2);
        ms_clock += $urandom_range(1, 50);
        push_scan(g1, g2, ms_clock);
        idle_words(g1, g2);
        press_key(k, g1, g2);
        if ($urandom_range(0, 3) == 0)
            press_key($urandom_range(1, KEY_COUNT), g1, g2);
        ms_clock += $urandom_range(0, 20);
        push_scan(g1, g2, ms_clock);
        n = $urandom_range(2, 10);
        for (int j = 0; j < n; j++)
        begin
            ms_clock += hold_gap();
            idle_words(g1, g2);
            // now and then the held key lets go for a scan
            if ($urandom_range(0, 14) != 0)
                press_key(k, g1, g2);
            if ($urandom_range(0, 4) == 0)
                press_key($urandom_range(1, KEY_COUNT), g1, g2);
            push_scan(g1, g2, ms_clock);
            if ($urandom_range(0, 14) == 0)
                push_forget();
        end
    endtask

    task automatic random_phase(input int target);
        int base;
        base = stim_count;
        while (stim_count - base < target)
        begin
            if ($urandom_range(0, 39) == 0)
                ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 70000);
            if ($urandom_range(0, 6) == 0)
            begin
                // raw noise scan or forget
                if ($urandom_range(0, 7) == 0)
                    push_forget();
                else
                    push_scan(g1_t'($urandom), g2_t'($urandom),
                              $urandom_range(0, 1) ? ms_t'($urandom)
                                                   : ms_clock + $urandom_range(0, 1000));
            end
            else
            begin
                hold_run($urandom_range(1, KEY_COUNT));
            end
        end
    endtask

    // wait until every scan has gone in and every event has come out
    task automatic wait_idle();
        while (pending_scans.size() != 0 || s_tvalid || key_events_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input delay_t data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FIRST_DELAY)
            first_delay_q = data;
        else if (idx == CFG_REPEAT_DELAY)
            repeat_delay_q = data;
    endtask

    initial
    begin
        g1_t g1;
        g2_t g2;
        delay_t d;

        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (KEY_IN_GROUP2[i])
                used_g2 = used_g2 | KEY_MASK[i][G2_W-1:0];
            else
                used_g1 = used_g1 | KEY_MASK[i];
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset delays
        // first scan after reset: history reads all pressed, so no click
        push_scan('0, '0, 32'd0);
        push_scan('1, '1, 32'd10);
        // each key alone in turn
        for (int k = 1; k <= KEY_COUNT; k++)
        begin
            g1 = '1;
            g2 = '1;
            press_key(k, g1, g2);
            push_scan(g1, g2, ms_t'(20 + k));
        end
        push_scan('1, '1, 32'd40);
        // hold key 5: exactly at each delay nothing, one past it repeats
        g1 = '1;
        g2 = '1;
        press_key(5, g1, g2);
        push_scan(g1, g2, 32'd1000);
        push_scan(g1, g2, 32'd1500);
        push_scan(g1, g2, 32'd1501);
        push_scan(g1, g2, 32'd1676);
        push_scan(g1, g2, 32'd1677);
        // forget while held, then the still pressed key neither clicks nor repeats
        push_forget();
        push_scan(g1, g2, 32'd5000);
        // hold across the tick wrap
        push_scan('1, '1, 32'hFFFF_FE00);
        g1 = '1;
        g2 = '1;
        press_key(9, g1, g2);
        push_scan(g1, g2, 32'hFFFF_FF00);
        push_scan(g1, g2, 32'h0000_0100);
        push_scan('0, '0, 32'hFFFF_FFFF);
        ms_clock = 32'd6000;
        random_phase(PHASE_ITEMS);

        // shortest nonzero delays
        wait_idle();
        write_reg(CFG_FIRST_DELAY, 16'd1);
        write_reg(CFG_REPEAT_DELAY, 16'd1);
        random_phase(PHASE_ITEMS);

        // longest delays, writes past the register list must not land
        wait_idle();
        write_reg(CFG_FIRST_DELAY, 16'hFFFF);
        write_reg(CFG_REPEAT_DELAY, 16'hFFFF);
        write_reg(CFG_SPARE_IDX, delay_t'($urandom));
        write_reg(CFG_TOP_IDX, delay_t'($urandom));
        random_phase(PHASE_ITEMS);

        // zero delays: repeat on every scan where the tick moved on
        wait_idle();
        write_reg(CFG_FIRST_DELAY, 16'd0);
        write_reg(CFG_REPEAT_DELAY, 16'd0);
        random_phase(PHASE_ITEMS);

        wait_idle();
        d = delay_t'($urandom_range(1, 600));
        write_reg(CFG_FIRST_DELAY, d);
        d = delay_t'($urandom_range(1, 600));
        write_reg(CFG_REPEAT_DELAY, d);
        random_phase(PHASE_ITEMS);

        wait_idle();
        d = delay_t'($urandom_range(1, 65535));
        write_reg(CFG_FIRST_DELAY, d);
        d = delay_t'($urandom_range(1, 65535));
        write_reg(CFG_REPEAT_DELAY, d);
        random_phase(PHASE_ITEMS);

        // last stretch at full rate on both sides
        wait_idle();
        quiet_tail = 1'b1;
        d = delay_t'($urandom_range(1, 300));
        write_reg(CFG_FIRST_DELAY, d);
        d = delay_t'($urandom_range(1, 300));
        write_reg(CFG_REPEAT_DELAY, d);
        random_phase(PHASE_ITEMS);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && key_events_due.size() == 0)
            $display("** key_autorepeat_detector: PASSED **");
        else
            $display("** key_autorepeat_detector: FAILED **");
        $finish;
    end

endmodule
